// ----- rtl/indexed_sequence_store_unit_macros.svh -----
// Assertion macros shared by the sequence store.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH

// Check that cond implies cons in the same cycle.
`define ISSU_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that cond implies cons in the following cycle.
`define ISSU_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/issu_pkg.sv -----
`timescale 1ns / 1ps
package issu_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
   localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_READ
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type     kind;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_READ,
      STATE_FINISH
   } state_type;

endpackage

// ----- rtl/issu_cell.sv -----
`timescale 1ns / 1ps
module issu_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  issu_pkg::cell_cmd_type       cmd,
   input  logic [CNT_W-1:0]             cell_pos,
   input  logic [issu_pkg::DATA_W-1:0]  left_entry,
   input  logic [issu_pkg::DATA_W-1:0]  right_entry,
   input  logic [issu_pkg::DATA_W-1:0]  right_tap,
   output logic [issu_pkg::DATA_W-1:0]  entry,
   output logic [issu_pkg::DATA_W-1:0]  tap
);

   localparam logic [CNT_W-1:0] CELL_INDEX = CNT_W'(INDEX);

   logic [issu_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic [issu_pkg::DATA_W-1:0] tap_ff, tap_in;

   always_comb begin
      entry_in = entry_ff;
      tap_in   = tap_ff;
      case (cmd.kind)
         issu_pkg::CELL_INSERT: begin
            // shift up above the slot, load the new value into it
            if (CELL_INDEX > cell_pos) begin
               entry_in = left_entry;
            end else if (CELL_INDEX == cell_pos) begin
               entry_in = cmd.value;
            end
         end
         issu_pkg::CELL_DELETE: begin
            if (CELL_INDEX >= cell_pos) begin
               entry_in = right_entry;
            end
         end
         issu_pkg::CELL_READ: begin
            // the addressed cell injects its entry, the rest pass towards cell 0
            tap_in = (CELL_INDEX == cell_pos) ? entry_ff : right_tap;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

// ----- rtl/indexed_sequence_store_unit.sv -----
`timescale 1ns / 1ps
// Positional insert/delete list of up to CAPACITY signed 32-bit entries, held as a row of
// cells, one entry per cell. A request transfers at a rising edge with start high and busy
// low; its single result appears later on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, and the receiver cannot stall it, so capture it on the strobe. Head, tail,
// insert and delete shift the whole row at once: the result comes in the next cycle and
// busy stays low, so a request may follow every cycle. A successful get moves the
// addressed entry down the read chain one cell per cycle towards cell 0, and busy is
// high until its result comes. A get that is out of range answers in the next cycle.
// After reset the store is empty; no clearing pass is needed.
`include "indexed_sequence_store_unit_macros.svh"

module indexed_sequence_store_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic        [issu_pkg::OP_W-1:0]      req_opcode,
   input  logic signed [issu_pkg::POS_W-1:0]     req_position,
   input  logic signed [issu_pkg::DATA_W-1:0]    req_item_value,
   output logic                                  rsp_strobe,
   output logic signed [issu_pkg::DATA_W-1:0]    rsp_read_value,
   output logic        [issu_pkg::STATUS_W-1:0]  rsp_status,
   output logic        [issu_pkg::LEN_W-1:0]     rsp_length
);

   // count holds 0 to CAPACITY; compares run at the wider of count and position
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > issu_pkg::POS_W) ? CNT_W : issu_pkg::POS_W;

   issu_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;      // position held for the read chain
   logic [CNT_W-1:0] cnt_ff, cnt_in;      // read steps still to go

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [issu_pkg::DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [issu_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [issu_pkg::LEN_W-1:0]        rsp_length_ff, rsp_length_in;

   // request decode
   logic                              accept;
   logic                              pos_negative;
   logic [CMP_W-1:0]                  pos_ext;
   logic [CMP_W-1:0]                  count_ext;
   logic                              store_full;
   logic [issu_pkg::STATUS_W-1:0]     dec_status;
   issu_pkg::cell_kind_type           dec_kind;
   logic [CNT_W-1:0]                  dec_pos;
   logic                              dec_read;

   // cell row
   issu_pkg::cell_cmd_type            cell_cmd;
   logic [CNT_W-1:0]                  cell_pos;
   logic [issu_pkg::DATA_W-1:0]       entry_w [CAPACITY];
   logic [issu_pkg::DATA_W-1:0]       tap_w   [CAPACITY];

   assign accept       = start && (state_ff == issu_pkg::STATE_IDLE);
   assign pos_negative = req_position[issu_pkg::POS_W-1];
   assign pos_ext      = CMP_W'($unsigned(req_position));
   assign count_ext    = CMP_W'(count_ff);
   assign store_full   = (count_ff == CNT_W'(CAPACITY));

   // Classify the request: range checks come before the full check on insert.
   always_comb begin
      dec_status = issu_pkg::STATUS_OK;
      dec_kind   = issu_pkg::CELL_HOLD;
      dec_pos    = CNT_W'(pos_ext);
      dec_read   = 1'b0;
      case (req_opcode)
         issu_pkg::OP_GET: begin
            if (pos_negative || (pos_ext >= count_ext)) begin
               dec_status = issu_pkg::STATUS_RANGE;
            end else begin
               dec_read = 1'b1;
            end
         end
         issu_pkg::OP_HEAD: begin
            dec_pos = '0;
            if (store_full) begin
               dec_status = issu_pkg::STATUS_FULL;
            end else begin
               dec_kind = issu_pkg::CELL_INSERT;
            end
         end
         issu_pkg::OP_TAIL: begin
            dec_pos = count_ff;
            if (store_full) begin
               dec_status = issu_pkg::STATUS_FULL;
            end else begin
               dec_kind = issu_pkg::CELL_INSERT;
            end
         end
         issu_pkg::OP_INSERT: begin
            if (pos_negative || (pos_ext > count_ext)) begin
               dec_status = issu_pkg::STATUS_RANGE;
            end else if (store_full) begin
               dec_status = issu_pkg::STATUS_FULL;
            end else begin
               dec_kind = issu_pkg::CELL_INSERT;
            end
         end
         issu_pkg::OP_DELETE: begin
            if (pos_negative || (pos_ext >= count_ext)) begin
               dec_status = issu_pkg::STATUS_RANGE;
            end else begin
               dec_kind = issu_pkg::CELL_DELETE;
            end
         end
         default: begin
            // unknown opcodes: answer ok, leave the store alone
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         issu_pkg::STATE_IDLE: begin
            if (accept && dec_read) begin
               state_in = issu_pkg::STATE_READ;
            end
         end
         issu_pkg::STATE_READ: begin
            if (cnt_ff == '0) begin
               state_in = issu_pkg::STATE_FINISH;
            end
         end
         issu_pkg::STATE_FINISH: begin
            state_in = issu_pkg::STATE_IDLE;
         end
         default: begin
            state_in = issu_pkg::STATE_IDLE;
         end
      endcase
   end

   // Outputs, cell commands and register updates.
   always_comb begin
      busy           = (state_ff != issu_pkg::STATE_IDLE);
      cell_cmd.kind  = issu_pkg::CELL_HOLD;
      cell_cmd.value = req_item_value;
      cell_pos       = pos_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      rsp_strobe_in  = 1'b0;
      rsp_value_in   = '0;
      rsp_status_in  = rsp_status_ff;
      rsp_length_in  = rsp_length_ff;
      case (state_ff)
         issu_pkg::STATE_IDLE: begin
            if (accept) begin
               cell_cmd.kind = dec_kind;
               cell_pos      = dec_pos;
               if (dec_read) begin
                  // hold the position and start the walk down the read chain
                  pos_in = dec_pos;
                  cnt_in = dec_pos;
               end else begin
                  case (dec_kind)
                     issu_pkg::CELL_INSERT: count_in = count_ff + CNT_W'(1);
                     issu_pkg::CELL_DELETE: count_in = count_ff - CNT_W'(1);
                     default:               count_in = count_ff;
                  endcase
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dec_status;
                  rsp_length_in = issu_pkg::LEN_W'(count_in);
               end
            end
         end
         issu_pkg::STATE_READ: begin
            // advance the read chain one cell
            cell_cmd.kind = issu_pkg::CELL_READ;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         issu_pkg::STATE_FINISH: begin
            // the addressed entry has reached cell 0
            rsp_strobe_in = 1'b1;
            rsp_value_in  = tap_w[0];
            rsp_status_in = issu_pkg::STATUS_OK;
            rsp_length_in = issu_pkg::LEN_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= issu_pkg::STATE_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and walk registers: no reset needed
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Row of cells: entries shift through left/right neighbours, reads flow towards cell 0.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [issu_pkg::DATA_W-1:0] left_w;
      logic [issu_pkg::DATA_W-1:0] right_w;
      logic [issu_pkg::DATA_W-1:0] right_tap_w;

      if (i == 0) begin : g_first
         assign left_w = cell_cmd.value;
      end else begin : g_inner_left
         assign left_w = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w     = '0;
         assign right_tap_w = '0;
      end else begin : g_inner_right
         assign right_w     = entry_w[i+1];
         assign right_tap_w = tap_w[i+1];
      end

      issu_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .cell_pos    (cell_pos),
         .left_entry  (left_w),
         .right_entry (right_w),
         .right_tap   (right_tap_w),
         .entry       (entry_w[i]),
         .tap         (tap_w[i])
      );
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

   // A transfer other than get answers in the next cycle.
   `ISSU_ASSERT_NEXT(a_quick_answer, clock, reset, start && !busy && (req_opcode != issu_pkg::OP_GET), rsp_strobe, "missing response after a one-cycle request")
   // The read walk never shows a result while it runs.
   `ISSU_ASSERT_SAME(a_quiet_walk, clock, reset, state_ff == issu_pkg::STATE_READ, !rsp_strobe_ff, "response strobe during read walk")
   // The finishing cycle delivers the get result and frees the block.
   `ISSU_ASSERT_NEXT(a_get_done, clock, reset, state_ff == issu_pkg::STATE_FINISH, rsp_strobe && !busy && (rsp_status == issu_pkg::STATUS_OK), "get result not delivered")
   // A full answer reports a full store.
   `ISSU_ASSERT_SAME(a_full_len, clock, reset, rsp_strobe && (rsp_status == issu_pkg::STATUS_FULL), rsp_length == issu_pkg::LEN_W'(CAPACITY), "full status with short length")

endmodule

// ----- dv/indexed_sequence_store_unit_tb.sv -----
`timescale 1ns / 1ps
module indexed_sequence_store_unit_tb;

   localparam int CAPACITY       = 64;
   // A valid get at the deepest slot is the slowest request.
   localparam int DRAIN_CYCLES   = CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int PHASE_ITEMS    = 120;
   // Window of random items sent back to back, with no sender gaps at all.
   localparam int CALM_FROM      = 400;
   localparam int CALM_TO        = 650;
   localparam int DIRECTED_ROWS  = 30;

   // Opcodes outside the defined set: the block must answer ok and leave the store alone.
   localparam logic [issu_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [issu_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef enum logic [1:0] {
      BIAS_GROW,
      BIAS_SHRINK,
      BIAS_MIXED
   } store_bias_type;

   typedef struct packed {
      logic signed [issu_pkg::DATA_W-1:0] read_value;
      logic [issu_pkg::STATUS_W-1:0]      status;
      logic [issu_pkg::LEN_W-1:0]         length;
   } response_type;

   typedef struct packed {
      logic [issu_pkg::OP_W-1:0]          opcode;
      logic signed [issu_pkg::POS_W-1:0]  position;
      logic signed [issu_pkg::DATA_W-1:0] item_value;
      logic                               repeat_to_full;
      logic                               has_answer;
      response_type                       rsp;
   } stimulus_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [issu_pkg::OP_W-1:0]            req_opcode;
   logic signed [issu_pkg::POS_W-1:0]    req_position;
   logic signed [issu_pkg::DATA_W-1:0]   req_item_value;
   logic                                 rsp_strobe;
   logic signed [issu_pkg::DATA_W-1:0]   rsp_read_value;
   logic [issu_pkg::STATUS_W-1:0]        rsp_status;
   logic [issu_pkg::LEN_W-1:0]           rsp_length;

   // Shadow copy of the sequence, kept in step with every accepted transfer.
   logic signed [issu_pkg::DATA_W-1:0]   seq_entries [CAPACITY];
   int unsigned                          seq_length = 0;
   response_type                         awaited_responses [$];
   int                                   error_count = 0;
   int                                   quiet_cycles = 0;

   // Directed rows. Where has_answer is set, the result is typed in and stands in
   // place of the prediction; the shadow store is advanced either way. A row with
   // repeat_to_full is sent again and again until the store holds CAPACITY entries.
   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty store: every positional request is out of range
      '{issu_pkg::OP_GET,    8'sd0,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd0}},
      '{issu_pkg::OP_DELETE, 8'sd0,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd0}},
      '{issu_pkg::OP_INSERT, 8'sd1,   32'sd5,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd0}},
      '{issu_pkg::OP_INSERT, 8'sh80,  32'sd5,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd0}},
      // value extremes; head and tail ignore the position
      '{issu_pkg::OP_TAIL,   8'sd127, 32'sh7FFF_FFFF, 1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd1}},
      '{issu_pkg::OP_HEAD,   -8'sd1,  32'sh8000_0000, 1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd2}},
      '{issu_pkg::OP_GET,    8'sd0,   32'sd0,         1'b0, 1'b1,
        '{32'sh8000_0000, issu_pkg::STATUS_OK, 7'd2}},
      '{issu_pkg::OP_GET,    8'sd1,   32'sd0,         1'b0, 1'b1,
        '{32'sh7FFF_FFFF, issu_pkg::STATUS_OK, 7'd2}},
      '{issu_pkg::OP_GET,    8'sd2,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd2}},
      '{issu_pkg::OP_GET,    8'sd127, 32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd2}},
      // insert in the middle and at position equal to the length
      '{issu_pkg::OP_INSERT, 8'sd1,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd3}},
      '{issu_pkg::OP_INSERT, 8'sd3,   -32'sd1,        1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd4}},
      '{issu_pkg::OP_GET,    8'sd1,   32'sd0,         1'b0, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}},
      '{issu_pkg::OP_GET,    8'sd3,   32'sd0,         1'b0, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}},
      // unknown opcodes leave the store alone
      '{OP_UNUSED_LO,        8'sd0,   32'sd1,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd4}},
      '{OP_UNUSED_HI,        8'sd1,   -32'sd1,        1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd4}},
      // delete: negative, one past the end, head, last entry
      '{issu_pkg::OP_DELETE, -8'sd1,  32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd4}},
      '{issu_pkg::OP_DELETE, 8'sd4,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd4}},
      '{issu_pkg::OP_DELETE, 8'sd0,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd3}},
      '{issu_pkg::OP_DELETE, 8'sd2,   32'sd0,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd2}},
      '{issu_pkg::OP_GET,    8'sd0,   32'sd0,         1'b0, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}},
      // fill to capacity, then every add is dropped
      '{issu_pkg::OP_TAIL,   8'sd0,   32'sh5A5A_5A5A, 1'b1, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}},
      '{issu_pkg::OP_HEAD,   8'sd0,   32'sd7,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_FULL, 7'd64}},
      '{issu_pkg::OP_TAIL,   8'sd0,   32'sd7,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_FULL, 7'd64}},
      '{issu_pkg::OP_INSERT, 8'sd64,  32'sd7,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_FULL, 7'd64}},
      // out of range wins over full
      '{issu_pkg::OP_INSERT, 8'sd65,  32'sd7,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd64}},
      '{issu_pkg::OP_INSERT, -8'sd1,  32'sd7,         1'b0, 1'b1,
        '{32'sd0, issu_pkg::STATUS_RANGE, 7'd64}},
      '{issu_pkg::OP_GET,    8'sd63,  32'sd0,         1'b0, 1'b1,
        '{32'sh5A5A_5A5A, issu_pkg::STATUS_OK, 7'd64}},
      '{issu_pkg::OP_DELETE, 8'sd63,  32'sd0,         1'b0, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}},
      '{issu_pkg::OP_DELETE, 8'sd0,   32'sd0,         1'b0, 1'b0,
        '{32'sd0, issu_pkg::STATUS_OK, 7'd0}}
   };

   store_bias_type phase_plan [3] = '{BIAS_SHRINK, BIAS_GROW, BIAS_MIXED};

   indexed_sequence_store_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_position  (req_position),
      .req_item_value(req_item_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Place a value at slot, shifting later entries up; drop it if the store is full.
   function automatic logic [issu_pkg::STATUS_W-1:0] add_entry(
      input int unsigned slot,
      input logic signed [issu_pkg::DATA_W-1:0] val);
      int unsigned k;
      if (seq_length >= CAPACITY) begin
         return issu_pkg::STATUS_FULL;
      end
      for (k = seq_length; k > slot; k--) begin
         seq_entries[k] = seq_entries[k - 1];
      end
      seq_entries[slot] = val;
      seq_length++;
      return issu_pkg::STATUS_OK;
   endfunction

   // Advance the shadow store by one request and work out the block's answer.
   task automatic predict_store_request(input logic [issu_pkg::OP_W-1:0] op,
                                        input logic signed [issu_pkg::POS_W-1:0] pos,
                                        input logic signed [issu_pkg::DATA_W-1:0] val,
                                        output response_type rsp);
      int unsigned slot;
      int unsigned k;
      logic        negative;
      negative = pos[issu_pkg::POS_W-1];
      slot = int'(pos[issu_pkg::POS_W-2:0]);
      rsp.read_value = '0;
      rsp.status = issu_pkg::STATUS_OK;
      case (op)
         issu_pkg::OP_GET: begin
            if (negative || slot >= seq_length) rsp.status = issu_pkg::STATUS_RANGE;
            else rsp.read_value = seq_entries[slot];
         end
         issu_pkg::OP_HEAD: begin
            rsp.status = add_entry(0, val);
         end
         issu_pkg::OP_TAIL: begin
            rsp.status = add_entry(seq_length, val);
         end
         issu_pkg::OP_INSERT: begin
            if (negative || slot > seq_length) rsp.status = issu_pkg::STATUS_RANGE;
            else rsp.status = add_entry(slot, val);
         end
         issu_pkg::OP_DELETE: begin
            if (negative || slot >= seq_length) begin
               rsp.status = issu_pkg::STATUS_RANGE;
            end else begin
               // close the gap left by the removed entry
               for (k = slot; k + 1 < seq_length; k++) begin
                  seq_entries[k] = seq_entries[k + 1];
               end
               seq_length--;
            end
         end
         default: ;
      endcase
      rsp.length = seq_length[issu_pkg::LEN_W-1:0];
   endtask

   // Weighted opcode choice: a growing phase fills the store, a shrinking one drains it.
   function automatic logic [issu_pkg::OP_W-1:0] pick_opcode(input store_bias_type bias);
      int roll;
      int w_get;
      int w_head;
      int w_tail;
      int w_ins;
      int w_del;
      roll = $urandom_range(99);
      case (bias)
         BIAS_GROW:   begin w_get = 10; w_head = 25; w_tail = 25; w_ins = 25; w_del = 12; end
         BIAS_SHRINK: begin w_get = 20; w_head = 5;  w_tail = 5;  w_ins = 5;  w_del = 62; end
         default:     begin w_get = 25; w_head = 15; w_tail = 15; w_ins = 20; w_del = 22; end
      endcase
      if (roll < w_get) return issu_pkg::OP_GET;
      roll -= w_get;
      if (roll < w_head) return issu_pkg::OP_HEAD;
      roll -= w_head;
      if (roll < w_tail) return issu_pkg::OP_TAIL;
      roll -= w_tail;
      if (roll < w_ins) return issu_pkg::OP_INSERT;
      roll -= w_ins;
      if (roll < w_del) return issu_pkg::OP_DELETE;
      return issu_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
   endfunction

   // Mostly in range for the opcode at hand; now and then any 8-bit value at all.
   function automatic logic signed [issu_pkg::POS_W-1:0] pick_position(
      input logic [issu_pkg::OP_W-1:0] op);
      if ($urandom_range(99) < 15) return issu_pkg::POS_W'($urandom());
      if (op == issu_pkg::OP_INSERT) return issu_pkg::POS_W'($urandom_range(seq_length, 0));
      if (seq_length == 0) return '0;
      return issu_pkg::POS_W'($urandom_range(seq_length - 1, 0));
   endfunction

   // Drive one request from a falling edge and hold it until the transfer, then
   // record what the block must answer. Leaves start high, at the next falling edge.
   task automatic send_request(input stimulus_row_type row);
      response_type predicted;
      req_opcode     <= row.opcode;
      req_position   <= row.position;
      req_item_value <= row.item_value;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_store_request(row.opcode, row.position, row.item_value, predicted);
      awaited_responses.push_back(row.has_answer ? row.rsp : predicted);
      @(negedge clock);
   endtask

   // Drop start for a number of cycles and put noise on the request fields.
   task automatic hold_off(input int cycles);
      start          <= 1'b0;
      req_opcode     <= issu_pkg::OP_W'($urandom());
      req_position   <= issu_pkg::POS_W'($urandom());
      req_item_value <= $urandom();
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      stimulus_row_type row;
      store_bias_type   bias;
      int               item;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = '0;
      req_position   = '0;
      req_item_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table first, back to back.
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         send_request(row);
         while (row.repeat_to_full && seq_length < CAPACITY) send_request(row);
      end

      // Random traffic in phases that drain, fill and churn the store.
      for (item = 0; item < RANDOM_ITEMS; item++) begin
         bias = phase_plan[(item / PHASE_ITEMS) % 3];
         row.opcode         = pick_opcode(bias);
         row.position       = pick_position(row.opcode);
         row.item_value     = $urandom();
         row.repeat_to_full = 1'b0;
         row.has_answer     = 1'b0;
         row.rsp            = '0;
         send_request(row);
         if ((item < CALM_FROM || item >= CALM_TO) && $urandom_range(99) < 6) begin
            hold_off($urandom_range(4, 1));
         end
      end
      hold_off(1);

      // Wait for the last answers, then give the block time to show any stray strobe.
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("indexed_sequence_store_unit_tb: clean");
      end else begin
         $display("indexed_sequence_store_unit_tb: errors");
      end
      $finish;
   end

   // Capture each result on its strobe and compare it with the oldest prediction.
   always @(posedge clock) begin : check_results
      response_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected result: read_value %0d status %0d length %0d",
                     $time, rsp_read_value, rsp_status, rsp_length);
            error_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d, got %0d",
                        $time, want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_length !== want.length) begin
               $display("%0t: length expected %0d, got %0d", $time, want.length, rsp_length);
               error_count++;
            end
         end
      end
   end

   // Abandon the run if neither a transfer nor a result happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no activity for %0d cycles", $time, quiet_cycles);
         $display("indexed_sequence_store_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
